// ----- hdl/rsdb_pkg.sv -----
// galois field helpers, generator coefficients and basis tables for the rs dual basis encoder
package rsdb_pkg;

    localparam logic [7:0] GF_POLY_LOW = 8'h87;
    localparam int         FIRST_ROOT  = 112;
    localparam int         ROOT_STEP   = 11;
    localparam int         GF_ORDER    = 255;
    localparam int         MAX_ROOTS   = 32;

    localparam logic [7:0] DUAL_ROWS [8] = '{
        8'h8d, 8'hef, 8'hec, 8'h86, 8'hfa, 8'h99, 8'haf, 8'h7b
    };

    typedef logic [255:0][7:0] t_tab;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    function automatic logic [7:0] gf_xtime(input logic [7:0] v);
        gf_xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            p = gf_xtime(p) ^ (b[i] ? a : 8'h00);
        end
        gf_mul = p;
    endfunction

    // alpha^k, elaboration only
    function automatic logic [7:0] gf_pow(input int k);
        logic [7:0] v;
        v = 8'h01;
        for (int i = 0; i < GF_ORDER; i++) begin
            if (i < k) begin
                v = gf_xtime(v);
            end
        end
        gf_pow = v;
    endfunction

    // coefficient idx of the generator polynomial with nroots roots
    function automatic logic [7:0] gen_coef(input int nroots, input int idx);
        logic [7:0] g [MAX_ROOTS+1];
        logic [7:0] r;
        for (int j = 0; j <= MAX_ROOTS; j++) begin
            g[j] = 8'h00;
        end
        g[0] = 8'h01;
        for (int i = 0; i < MAX_ROOTS; i++) begin
            if (i < nroots) begin
                r        = gf_pow(((FIRST_ROOT + i) * ROOT_STEP) % GF_ORDER);
                g[i + 1] = 8'h01;
                for (int j = MAX_ROOTS; j > 0; j--) begin
                    if (j <= i) begin
                        g[j] = g[j - 1] ^ gf_mul(g[j], r);
                    end
                end
                g[0] = gf_mul(g[0], r);
            end
        end
        gen_coef = g[idx];
    endfunction

    function automatic logic [7:0] to_dual(input logic [7:0] x);
        logic [7:0] d;
        d = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (x[k]) begin
                d = d ^ DUAL_ROWS[7 - k];
            end
        end
        to_dual = d;
    endfunction

    function automatic t_tab build_from_dual();
        t_tab t;
        for (int i = 0; i < 256; i++) begin
            t[to_dual(8'(i))] = 8'(i);
        end
        build_from_dual = t;
    endfunction

    localparam t_tab FROM_DUAL = build_from_dual();

endpackage

// ----- hdl/rs_255_223_dual_basis_encoder.sv -----
// top level of the ccsds reed-solomon encoder with dual basis symbols
// Takes one dual-basis message byte per cycle while o_stall is low and echoes it through a
// single output register while a chain of NROOTS parity cells (one constant gf multiplier
// each) updates the remainder. A byte marked last, or the (255-NROOTS)th byte, ends the
// codeword: the parity bytes then shift out of the cell chain, one per cycle unless i_stall
// holds the output, converted to dual basis, with the last one flagged. While the single
// output port drains the chain, o_stall stays high.
module rs_255_223_dual_basis_encoder
    import rsdb_pkg::*;
#(
    parameter int NROOTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_msg_byte,
    input  logic       i_msg_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_code_byte,
    output logic       o_is_parity,
    output logic       o_code_last
);

    localparam int         CNT_W   = $clog2(NROOTS);
    localparam logic [8:0] MSG_LEN = 9'(255 - NROOTS);

    logic [7:0]       w_par [NROOTS+1];
    logic [7:0]       w_fb;
    logic             w_out_free;
    logic             w_accept;
    logic             w_end;
    logic             w_drain_step;
    logic             w_par_any;
    t_cell_ctl        w_ctl;

    logic             r_drain;
    logic             n_drain;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [7:0]       r_count;
    logic [7:0]       n_count;
    logic             r_o_valid;
    logic             n_o_valid;
    logic [7:0]       r_o_byte;
    logic [7:0]       n_o_byte;
    logic             r_o_par;
    logic             n_o_par;
    logic             r_o_last;
    logic             n_o_last;

    assign w_out_free   = !r_o_valid || !i_stall;
    assign o_stall      = r_drain || !w_out_free;
    assign w_accept     = i_valid && !o_stall;
    assign w_drain_step = r_drain && w_out_free;
    assign w_fb         = FROM_DUAL[i_msg_byte] ^ w_par[0];
    assign w_end        = i_msg_last || ({1'b0, r_count} + 9'd1 >= MSG_LEN);

    assign w_ctl.load  = w_accept;
    assign w_ctl.shift = w_drain_step;

    assign w_par[NROOTS] = 8'h00;

    genvar c;
    generate
        for (c = 0; c < NROOTS; c++) begin : g_cell
            rsdb_cell #(
                .COEF(gen_coef(NROOTS, NROOTS - 1 - c))
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_fb   (w_fb),
                .i_next (w_par[c+1]),
                .o_par  (w_par[c])
            );
        end
    endgenerate

    always_comb begin
        w_par_any = 1'b0;
        for (int k = 0; k < NROOTS; k++) begin
            w_par_any = w_par_any | (|w_par[k]);
        end
    end

    always_comb begin
        n_drain   = r_drain;
        n_cnt     = r_cnt;
        n_count   = r_count;
        n_o_valid = r_o_valid && i_stall;
        n_o_byte  = r_o_byte;
        n_o_par   = r_o_par;
        n_o_last  = r_o_last;
        if (w_accept) begin
            n_o_valid = 1'b1;
            n_o_byte  = i_msg_byte;
            n_o_par   = 1'b0;
            n_o_last  = 1'b0;
            if (w_end) begin
                n_count = 8'h00;
                n_drain = 1'b1;
                n_cnt   = '0;
            end else begin
                n_count = r_count + 8'd1;
            end
        end else if (w_drain_step) begin
            n_o_valid = 1'b1;
            n_o_byte  = to_dual(w_par[0]);
            n_o_par   = 1'b1;
            n_o_last  = (r_cnt == CNT_W'(NROOTS - 1));
            n_cnt     = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NROOTS - 1)) begin
                n_drain = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain   <= 1'b0;
            r_cnt     <= '0;
            r_count   <= 8'h00;
            r_o_valid <= 1'b0;
        end else begin
            r_drain   <= n_drain;
            r_cnt     <= n_cnt;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_byte <= n_o_byte;
        r_o_par  <= n_o_par;
        r_o_last <= n_o_last;
    end

    assign o_valid     = r_o_valid;
    assign o_code_byte = r_o_byte;
    assign o_is_parity = r_o_par;
    assign o_code_last = r_o_last;

    // the final parity byte is always a parity byte
    a_last_is_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_code_last |-> o_is_parity)
        else $error("final symbol not marked as parity");

    // a request marked last starts the parity drain
    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_msg_last |=> r_drain)
        else $error("parity drain did not start after last request");

    // after the drain the cell chain is back to all zeros
    a_chain_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_drain) |-> !w_par_any)
        else $error("parity cells not cleared after drain");

    // the message counter never reaches a full block
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < MSG_LEN)
        else $error("symbol counter out of range");

endmodule

// ----- hdl/rsdb_cell.sv -----
// one parity cell of the encoder chain: lfsr tap on load, plain shift while parity drains
module rsdb_cell
    import rsdb_pkg::*;
#(
    parameter logic [7:0] COEF = 8'h01
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic [7:0] i_fb,
    input  logic [7:0] i_next,
    output logic [7:0] o_par
);

    logic [7:0] r_par;
    logic [7:0] n_par;

    always_comb begin
        n_par = r_par;
        if (i_ctl.load) begin
            n_par = i_next ^ gf_mul(i_fb, COEF);
        end else if (i_ctl.shift) begin
            n_par = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par <= 8'h00;
        end else begin
            r_par <= n_par;
        end
    end

    assign o_par = r_par;

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench for the ccsds rs(255,223) dual basis encoder
`timescale 1ns / 100ps

module tb_top;

    localparam int N_PAR     = 32;
    localparam int MSG_LEN   = 255 - N_PAR;
    localparam int CLK_LIMIT = 1000000;
    localparam int RPT_MAX   = 10;
    localparam int RND_ITEMS = 160;
    localparam int CALM_FROM = 125;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_ECHO,
        ROW_ZERO_CW
    } t_row_kind;

    typedef struct packed {
        logic [7:0] msg;
        logic       tail;
        t_row_kind  kind;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] sym;
        logic       is_par;
        logic       is_end;
    } t_code;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_msg_byte;
    logic       i_msg_last;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_code_byte;
    logic       o_is_parity;
    logic       o_code_last;

    rs_255_223_dual_basis_encoder #(
        .NROOTS(N_PAR)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_msg_byte  (i_msg_byte),
        .i_msg_last  (i_msg_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code_byte (o_code_byte),
        .o_is_parity (o_is_parity),
        .o_code_last (o_code_last)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // galois field tables and generator polynomial
    logic [7:0] gf_exp [256];
    logic [7:0] gf_log [256];
    logic [7:0] dual_of [256];
    logic [7:0] conv_of [256];
    logic [7:0] gen_poly [N_PAR+1];
    logic [7:0] basis_rows [8] = '{8'h8d, 8'hef, 8'hec, 8'h86, 8'hfa, 8'h99, 8'haf, 8'h7b};

    // encoder state as predicted
    logic [7:0] parity_rem [N_PAR];
    int         sym_count;

    t_code      expected_codes [$];
    int         err_count;
    int         cycle_count;
    bit         calm;
    int         stall_hold;

    t_stim_row  dir_rows [19] = '{
        '{8'h00, 1'b1, ROW_ZERO_CW},
        '{8'h00, 1'b1, ROW_ZERO_CW},
        '{8'hff, 1'b0, ROW_ECHO},
        '{8'h00, 1'b0, ROW_ECHO},
        '{8'h01, 1'b0, ROW_ECHO},
        '{8'h80, 1'b0, ROW_ECHO},
        '{8'haa, 1'b1, ROW_PREDICT},
        '{8'hff, 1'b1, ROW_PREDICT},
        '{8'h55, 1'b1, ROW_PREDICT},
        '{8'h01, 1'b1, ROW_PREDICT},
        '{8'h80, 1'b1, ROW_PREDICT},
        '{8'h7b, 1'b1, ROW_PREDICT},
        '{8'h00, 1'b0, ROW_ECHO},
        '{8'h00, 1'b0, ROW_ECHO},
        '{8'h7b, 1'b1, ROW_PREDICT},
        '{8'hff, 1'b0, ROW_ECHO},
        '{8'hff, 1'b0, ROW_ECHO},
        '{8'hff, 1'b1, ROW_PREDICT},
        '{8'h00, 1'b1, ROW_PREDICT}
    };

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        if (a == 8'h00 || b == 8'h00) begin
            return 8'h00;
        end
        return gf_exp[(int'(gf_log[a]) + int'(gf_log[b])) % 255];
    endfunction

    task automatic build_gf_tables();
        int         v;
        logic [7:0] d;
        logic [7:0] r;
        v = 1;
        for (int i = 0; i < 255; i++) begin
            gf_exp[i] = 8'(v);
            gf_log[v] = 8'(i);
            v = v << 1;
            if (v & 32'h100) begin
                v = v ^ 32'h187;
            end
            v = v & 32'hff;
        end
        gf_exp[255] = 8'h01;
        gf_log[0]   = 8'h00;
        for (int i = 0; i < 256; i++) begin
            d = 8'h00;
            for (int k = 0; k < 8; k++) begin
                if (i[k]) begin
                    d = d ^ basis_rows[7 - k];
                end
            end
            dual_of[i] = d;
            conv_of[d] = 8'(i);
        end
        for (int j = 0; j <= N_PAR; j++) begin
            gen_poly[j] = 8'h00;
        end
        gen_poly[0] = 8'h01;
        for (int i = 0; i < N_PAR; i++) begin
            r = gf_exp[((112 + i) * 11) % 255];
            gen_poly[i + 1] = 8'h01;
            for (int j = i; j > 0; j--) begin
                gen_poly[j] = gen_poly[j - 1] ^ gf_times(gen_poly[j], r);
            end
            gen_poly[0] = gf_times(gen_poly[0], r);
        end
    endtask

    task automatic clear_remainder();
        for (int j = 0; j < N_PAR; j++) begin
            parity_rem[j] = 8'h00;
        end
        sym_count = 0;
    endtask

    // appends one expected code byte at the tail of the queue
    task automatic queue_code(input t_code c);
        expected_codes.insert(expected_codes.size(), c);
    endtask

    // clocks one symbol into the predicted remainder, queues echo and parity if asked
    task automatic encode_symbol(input logic [7:0] sym, input logic tail, input bit record);
        logic [7:0] fb;
        t_code      c;
        fb = conv_of[sym] ^ parity_rem[0];
        for (int j = 1; j < N_PAR; j++) begin
            parity_rem[j - 1] = parity_rem[j] ^ gf_times(fb, gen_poly[N_PAR - j]);
        end
        parity_rem[N_PAR - 1] = gf_times(fb, gen_poly[0]);
        c = '{sym: sym, is_par: 1'b0, is_end: 1'b0};
        if (record) begin
            queue_code(c);
        end
        sym_count = (sym_count + 1) & 255;
        if (tail || sym_count >= MSG_LEN) begin
            for (int j = 0; j < N_PAR; j++) begin
                c = '{sym: dual_of[parity_rem[j]], is_par: 1'b1, is_end: (j == N_PAR - 1)};
                if (record) begin
                    queue_code(c);
                end
            end
            clear_remainder();
        end
    endtask

    task automatic send_symbol(input logic [7:0] sym, input logic tail, input t_row_kind kind);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_msg_byte <= sym;
        i_msg_last <= tail;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // typed rows: echo, and for a zero codeword from the reset state an all zero parity
        if (kind == ROW_ECHO || kind == ROW_ZERO_CW) begin
            queue_code('{sym: sym, is_par: 1'b0, is_end: 1'b0});
        end
        if (kind == ROW_ZERO_CW) begin
            for (int j = 0; j < N_PAR; j++) begin
                queue_code('{sym: 8'h00, is_par: 1'b1, is_end: (j == N_PAR - 1)});
            end
        end
        encode_symbol(sym, tail, kind == ROW_PREDICT);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hff;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    // result side: compare and drive random stall bursts
    always @(posedge i_clk) begin
        t_code want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_codes.size() == 0) begin
                err_count++;
                if (err_count <= RPT_MAX) begin
                    $display("unexpected code byte %02h parity %0b last %0b",
                             o_code_byte, o_is_parity, o_code_last);
                end
            end else begin
                want = expected_codes.pop_front();
                if (want.sym !== o_code_byte || want.is_par !== o_is_parity ||
                    want.is_end !== o_code_last) begin
                    err_count++;
                    if (err_count <= RPT_MAX) begin
                        $display("mismatch: expected byte %02h parity %0b last %0b, got %02h %0b %0b",
                                 want.sym, want.is_par, want.is_end,
                                 o_code_byte, o_is_parity, o_code_last);
                    end
                end
            end
        end
        if (calm) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_hold <= $urandom_range(0, 7);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLK_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int         rnd_count;
        int         cw_len;
        logic       tail;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_msg_byte  = 8'h00;
        i_msg_last  = 1'b0;
        i_stall     = 1'b0;
        stall_hold  = 0;
        err_count   = 0;
        cycle_count = 0;
        calm        = 1'b0;
        rnd_count   = 0;
        build_gf_tables();
        clear_remainder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_symbol(dir_rows[r].msg, dir_rows[r].tail, dir_rows[r].kind);
        end

        // random shortened codewords, mostly short, now and then long
        while (rnd_count < RND_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                cw_len = $urandom_range(100, MSG_LEN);
            end else begin
                cw_len = $urandom_range(1, 24);
            end
            if (cw_len > RND_ITEMS - rnd_count) begin
                cw_len = RND_ITEMS - rnd_count;
            end
            for (int s = 0; s < cw_len; s++) begin
                if (s == cw_len - 1) begin
                    tail = (cw_len == MSG_LEN) ? 1'($urandom) : 1'b1;
                end else begin
                    tail = 1'b0;
                end
                send_symbol(pick_byte(), tail, ROW_PREDICT);
                rnd_count++;
                if (rnd_count >= CALM_FROM) begin
                    calm = 1'b1;
                end
            end
        end
        i_valid <= 1'b0;

        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (2 * N_PAR + 8) @(posedge i_clk);

        if (err_count == 0 && expected_codes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rsdb_pkg.sv
hdl/rsdb_cell.sv
hdl/rs_255_223_dual_basis_encoder.sv
bench/tb_top.sv
